// ===== hdl/rlog_pkg.sv =====
// Shared types, constants and codes for the redo log transaction tracker.
package rlog_pkg;

  localparam int LOG_ENTRIES = 30;
  localparam int OP_BLOCKS   = 10;
  localparam int ACTIVE_MAX  = 15;

  localparam int WORD_W    = 32;
  localparam int SIZE_W    = 10;
  localparam int CNT_W     = 5;
  localparam int ACT_W     = 4;
  localparam int SUM_W     = 10;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOG_START = 1'd0,
    CFG_LOG_SIZE  = 1'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_END   = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_GRANTED = 3'd0,
    KIND_WAIT    = 3'd1,
    KIND_DONE    = 3'd2,
    KIND_COPY    = 3'd3,
    KIND_HEADER  = 3'd4,
    KIND_DIRECT  = 3'd5,
    KIND_ERROR   = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_TOO_BIG = 2'd1,
    ERR_OUTSIDE = 2'd2
  } err_e;

  typedef struct packed {
    op_e                operation;
    logic [WORD_W-1:0]  block_number;
  } in_item_t;

  typedef struct packed {
    kind_e              kind;
    err_e               error_code;
    logic [WORD_W-1:0]  source_block;
    logic [WORD_W-1:0]  dest_block;
    logic [CNT_W-1:0]   header_count;
    logic [CNT_W-1:0]   slot_index;
    logic               absorbed;
    logic               pin_buffer;
    logic               last;
  } out_item_t;

  // Result selector from the controller to the datapath
  typedef enum logic [3:0] {
    RES_GRANTED,
    RES_WAIT,
    RES_DONE,
    RES_ERR_BIG,
    RES_ERR_OUT,
    RES_DIRECT,
    RES_LOGGED,
    RES_COPY_OUT,
    RES_HDR_FULL,
    RES_COPY_BACK,
    RES_HDR_CLEAR
  } res_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SEARCH,
    ST_COPY_OUT,
    ST_HDR_FULL,
    ST_COPY_BACK,
    ST_HDR_CLEAR
  } state_e;

  typedef struct packed {
    logic load_item;
    logic clr_idx;
    logic inc_idx;
    logic act_inc;
    logic act_dec;
    logic tbl_write;
    logic cnt_inc;
    logic cnt_clr;
    logic out_load;
    res_e out_sel;
  } rlog_cmd_t;

  typedef struct packed {
    op_e  op;
    logic log_off;
    logic begin_blocked;
    logic active_zero;
    logic active_last;
    logic table_full;
    logic count_zero;
    logic at_count;
    logic hit;
    logic idx_last;
    logic out_free;
  } rlog_status_t;

endpackage

// ===== hdl/rlog_ctrl.sv =====
// Sequencing state machine for the redo log tracker.
module rlog_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rlog_pkg::rlog_status_t status_i,
  output rlog_pkg::rlog_cmd_t    cmd_o
);
  import rlog_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status_i.op == OP_NONE) begin
          state_d = ST_IDLE;
        end else if (status_i.out_free) begin
          if (status_i.op == OP_END && !status_i.log_off && !status_i.active_zero &&
              status_i.active_last && !status_i.count_zero) begin
            state_d = ST_COPY_OUT;
          end else if (status_i.op == OP_WRITE && !status_i.log_off &&
                       !status_i.table_full && !status_i.active_zero) begin
            state_d = ST_SEARCH;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SEARCH: begin
        if (status_i.out_free && (status_i.at_count || status_i.hit)) state_d = ST_IDLE;
      end
      ST_COPY_OUT: begin
        if (status_i.out_free && status_i.idx_last) state_d = ST_HDR_FULL;
      end
      ST_HDR_FULL: begin
        if (status_i.out_free) state_d = ST_COPY_BACK;
      end
      ST_COPY_BACK: begin
        if (status_i.out_free && status_i.idx_last) state_d = ST_HDR_CLEAR;
      end
      ST_HDR_CLEAR: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.out_sel = RES_GRANTED;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          cmd_o.clr_idx   = 1'b1;
        end
      end
      ST_DECIDE: begin
        if (status_i.out_free) begin
          unique case (status_i.op)
            OP_BEGIN: begin
              cmd_o.out_load = 1'b1;
              if (status_i.log_off) begin
                cmd_o.out_sel = RES_GRANTED;
              end else if (status_i.begin_blocked) begin
                cmd_o.out_sel = RES_WAIT;
              end else begin
                cmd_o.act_inc = 1'b1;
                cmd_o.out_sel = RES_GRANTED;
              end
            end
            OP_END: begin
              if (status_i.log_off) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_sel  = RES_DONE;
              end else if (status_i.active_zero) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_sel  = RES_ERR_OUT;
              end else begin
                cmd_o.act_dec = 1'b1;
                // Final end with logged blocks starts the commit sequence
                if (!(status_i.active_last && !status_i.count_zero)) begin
                  cmd_o.out_load = 1'b1;
                  cmd_o.out_sel  = RES_DONE;
                end
              end
            end
            OP_WRITE: begin
              if (status_i.log_off) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_sel  = RES_DIRECT;
              end else if (status_i.table_full) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_sel  = RES_ERR_BIG;
              end else if (status_i.active_zero) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_sel  = RES_ERR_OUT;
              end
            end
            OP_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (status_i.at_count) begin
          if (status_i.out_free) begin
            cmd_o.tbl_write = 1'b1;
            cmd_o.cnt_inc   = 1'b1;
            cmd_o.out_load  = 1'b1;
            cmd_o.out_sel   = RES_LOGGED;
          end
        end else if (status_i.hit) begin
          if (status_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = RES_LOGGED;
          end
        end else begin
          cmd_o.inc_idx = 1'b1;
        end
      end
      ST_COPY_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = RES_COPY_OUT;
          cmd_o.inc_idx  = !status_i.idx_last;
          cmd_o.clr_idx  = status_i.idx_last;
        end
      end
      ST_HDR_FULL: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = RES_HDR_FULL;
        end
      end
      ST_COPY_BACK: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = RES_COPY_BACK;
          cmd_o.inc_idx  = !status_i.idx_last;
          cmd_o.clr_idx  = status_i.idx_last;
        end
      end
      ST_HDR_CLEAR: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = RES_HDR_CLEAR;
          cmd_o.cnt_clr  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/rlog_dp.sv =====
// Datapath: config registers, block table, counters and result register.
module rlog_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rlog_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rlog_pkg::WORD_W-1:0]          cfg_data_i,
  input  rlog_pkg::in_item_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output rlog_pkg::out_item_t                  out_data_o,
  input  rlog_pkg::rlog_cmd_t                  cmd_i,
  output rlog_pkg::rlog_status_t               status_o
);
  import rlog_pkg::*;

  logic [WORD_W-1:0] log_start_q;
  logic [SIZE_W-1:0] log_size_q;
  op_e               op_q;
  logic [WORD_W-1:0] blk_q;
  logic [WORD_W-1:0] table_q [LOG_ENTRIES];
  logic [CNT_W-1:0]  count_q;
  logic [ACT_W-1:0]  active_q;
  logic [CNT_W-1:0]  idx_q;
  logic              out_valid_q;
  out_item_t         out_q, out_d;

  logic [WORD_W-1:0] tbl_rd;
  logic [WORD_W-1:0] log_addr;
  logic [SUM_W-1:0]  need_space;
  logic              out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_start_q <= '0;
      log_size_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LOG_START: log_start_q <= cfg_data_i;
        CFG_LOG_SIZE:  log_size_q  <= cfg_data_i[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q  <= in_data_i.operation;
      blk_q <= in_data_i.block_number;
    end
    if (cmd_i.tbl_write) table_q[idx_q] <= blk_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      active_q <= '0;
      idx_q    <= '0;
    end else begin
      if (cmd_i.cnt_clr) begin
        count_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.act_inc) begin
        active_q <= active_q + ACT_W'(1);
      end else if (cmd_i.act_dec) begin
        active_q <= active_q - ACT_W'(1);
      end
      if (cmd_i.clr_idx) begin
        idx_q <= '0;
      end else if (cmd_i.inc_idx) begin
        idx_q <= idx_q + CNT_W'(1);
      end
    end
  end

  // Index can equal the entry count at the end of a search; the read value is unused then
  assign tbl_rd     = table_q[idx_q];
  assign log_addr   = log_start_q + WORD_W'(1) + WORD_W'(idx_q);
  assign need_space = SUM_W'(count_q) +
                      SUM_W'({1'b0, active_q} + (ACT_W + 1)'(1)) * SUM_W'(OP_BLOCKS);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    status_o.op            = op_q;
    status_o.log_off       = (log_size_q == '0);
    status_o.begin_blocked = (active_q >= ACT_W'(ACTIVE_MAX)) ||
                             (need_space > SUM_W'(LOG_ENTRIES));
    status_o.active_zero   = (active_q == '0);
    status_o.active_last   = (active_q == ACT_W'(1));
    status_o.table_full    = (count_q >= CNT_W'(LOG_ENTRIES)) ||
                             (SIZE_W'(count_q) >= log_size_q - SIZE_W'(1));
    status_o.count_zero    = (count_q == '0);
    status_o.at_count      = (idx_q == count_q);
    status_o.hit           = (idx_q != count_q) && (tbl_rd == blk_q);
    status_o.idx_last      = (idx_q == count_q - CNT_W'(1));
    status_o.out_free      = out_free;
  end

  always_comb begin
    out_d            = '0;
    out_d.kind       = KIND_DONE;
    out_d.error_code = ERR_NONE;
    out_d.last       = 1'b1;
    unique case (cmd_i.out_sel)
      RES_GRANTED: out_d.kind = KIND_GRANTED;
      RES_WAIT:    out_d.kind = KIND_WAIT;
      RES_DONE:    out_d.kind = KIND_DONE;
      RES_ERR_BIG: begin
        out_d.kind       = KIND_ERROR;
        out_d.error_code = ERR_TOO_BIG;
      end
      RES_ERR_OUT: begin
        out_d.kind       = KIND_ERROR;
        out_d.error_code = ERR_OUTSIDE;
      end
      RES_DIRECT: begin
        out_d.kind       = KIND_DIRECT;
        out_d.dest_block = blk_q;
      end
      RES_LOGGED: begin
        out_d.kind       = KIND_DONE;
        out_d.slot_index = idx_q;
        out_d.absorbed   = (idx_q != count_q);
        out_d.pin_buffer = 1'b1;
      end
      RES_COPY_OUT: begin
        out_d.kind         = KIND_COPY;
        out_d.source_block = tbl_rd;
        out_d.dest_block   = log_addr;
        out_d.last         = 1'b0;
      end
      RES_HDR_FULL: begin
        out_d.kind         = KIND_HEADER;
        out_d.dest_block   = log_start_q;
        out_d.header_count = count_q;
        out_d.last         = 1'b0;
      end
      RES_COPY_BACK: begin
        out_d.kind         = KIND_COPY;
        out_d.source_block = log_addr;
        out_d.dest_block   = tbl_rd;
        out_d.last         = 1'b0;
      end
      RES_HDR_CLEAR: begin
        out_d.kind       = KIND_HEADER;
        out_d.dest_block = log_start_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/redo_log_transaction_tracker.sv =====
// Top level of the redo log transaction tracker.
// One request is worked at a time: the idle state takes the transfer and the decide state
// decides. Begin, end without commit, errors and direct writes then give their single
// result. A logged write walks the block table one entry per cycle. A commit emits one
// command per cycle through the single output register while the output side does not
// stall: it copies each entry out, writes the full header, copies each entry back and
// clears the header. A stall on the output side while a result is waiting holds the
// sequence. The next request is taken while the last result of the previous one still waits.
module redo_log_transaction_tracker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rlog_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rlog_pkg::WORD_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rlog_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rlog_pkg::out_item_t            out_data_o
);
  import rlog_pkg::*;

  rlog_cmd_t    cmd;
  rlog_status_t status;

  rlog_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rlog_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
